### src/ray_cylinder_intersect_assert.svh
// Assertion macros for the ray and cylinder intersection block.
`ifndef RAY_CYLINDER_INTERSECT_ASSERT_SVH
`define RAY_CYLINDER_INTERSECT_ASSERT_SVH
`ifndef SYNTHESIS
`define RCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ray_cylinder_intersect: assertion failed");
`define RCI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ray_cylinder_intersect: assertion failed");
`else
`define RCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RCI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/rci_pkg.sv
package rci_pkg;

    localparam int SQRT_STEPS = 64;
    localparam int TDIV_STEPS = 41;
    localparam int NDIV_STEPS = 15;

    localparam logic [TDIV_STEPS-1:0] T_LIMIT  = 41'h100_0000_0000;
    localparam logic [NDIV_STEPS-1:0] NORM_ONE = 15'd16384;

    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;
    localparam logic [30:0] HEIGHT_RESET = 31'd131072;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic signed [31:0] t_min;
        logic signed [31:0] t_max;
        logic               kind;
    } t_ray;

    typedef struct packed {
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } t_pp;

    typedef struct packed {
        logic [127:0] lohi;
        logic [64:0]  mid;
    } t_pm;

    typedef struct packed {
        logic [67:0]  rem;
        logic [63:0]  root;
        logic [127:0] x;
    } t_sqrt;

    typedef struct packed {
        logic [63:0]            rem;
        logic [TDIV_STEPS-1:0]  q;
        logic [TDIV_STEPS-1:0]  n;
    } t_tdiv;

    typedef struct packed {
        logic [63:0]            rem;
        logic [NDIV_STEPS-1:0]  q;
        logic [NDIV_STEPS-1:0]  n;
    } t_ndiv;

    function automatic t_pp mul_pp(input logic [63:0] a, input logic [63:0] b);
        t_pp r;
        r.p00 = a[31:0] * b[31:0];
        r.p01 = a[31:0] * b[63:32];
        r.p10 = a[63:32] * b[31:0];
        r.p11 = a[63:32] * b[63:32];
        return r;
    endfunction

    function automatic t_pm mul_mid(input t_pp p);
        t_pm r;
        r.lohi = {p.p11, p.p00};
        r.mid  = {1'b0, p.p01} + {1'b0, p.p10};
        return r;
    endfunction

    function automatic logic [127:0] mul_fin(input t_pm m);
        return m.lohi + {31'b0, m.mid, 32'b0};
    endfunction

    // One result bit of a floor square root, two radicand bits consumed.
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt       r;
        logic [67:0] rem2;
        logic [67:0] trial;
        rem2  = {s.rem[65:0], s.x[127:126]};
        trial = {2'b00, s.root, 2'b01};
        r.x   = {s.x[125:0], 2'b00};
        if (rem2 >= trial) begin
            r.rem  = rem2 - trial;
            r.root = {s.root[62:0], 1'b1};
        end else begin
            r.rem  = rem2;
            r.root = {s.root[62:0], 1'b0};
        end
        return r;
    endfunction

    // Restoring division step: returns the quotient bit above the new remainder.
    function automatic logic [64:0] div_step(input logic [63:0] rem, input logic bin,
                                             input logic [63:0] d);
        logic [64:0] sh;
        sh = {rem, bin};
        if (sh >= {1'b0, d}) begin
            sh = sh - {1'b0, d};
            return {1'b1, sh[63:0]};
        end
        return {1'b0, sh[63:0]};
    endfunction

endpackage

### src/ray_cylinder_intersect.sv
// Ray against uncapped finite cylinder about the z axis, fully pipelined.
// Throughput: one item per clock cycle; o_busy is never raised and nothing stalls.
// The pipeline length is set by two 64-stage square-root pipes and the root and normal dividers.
// Reset (synchronous, active low) empties the pipeline and restores radius 1.0, height 2.0.
`include "ray_cylinder_intersect_assert.svh"

module ray_cylinder_intersect import rci_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic signed [31:0] i_t_min,
    input  logic signed [31:0] i_t_max,
    input  logic               i_ray_kind,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [30:0]        i_cfg_wdata,
    output logic               o_done,
    output logic               o_hit,
    output logic signed [31:0] o_distance,
    output logic               o_normal_valid,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic               o_normal_z
);

    localparam int LAT = 20 + 2 * SQRT_STEPS + TDIV_STEPS + NDIV_STEPS;

    typedef struct packed {
        logic [63:0]        dxx;
        logic [63:0]        dyy;
        logic [63:0]        oxx;
        logic [63:0]        oyy;
        logic signed [63:0] oxdx;
        logic signed [63:0] oydy;
        logic [61:0]        rr;
    } t_prd;

    typedef struct packed {
        logic [63:0]        a;
        logic signed [64:0] h;
        logic [63:0]        hm;
        logic [63:0]        cm;
        logic               cneg;
        logic               miss;
    } t_abc;

    typedef struct packed {
        t_ray               ray;
        logic               miss;
        logic [63:0]        a;
        logic signed [64:0] h;
    } t_sd1;

    typedef struct packed {
        t_ray        ray;
        logic        miss;
        logic [63:0] a;
        logic        nn_neg;
        logic [64:0] nn_mag;
        logic        nf_neg;
        logic [64:0] nf_mag;
    } t_num;

    typedef struct packed {
        t_ray        ray;
        logic        miss;
        logic [63:0] a;
        logic        nn_neg;
        logic        nn_ovf;
        logic        nf_neg;
        logic        nf_ovf;
    } t_tside;

    typedef struct packed {
        t_ray               ray;
        logic               miss;
        logic signed [41:0] tn;
        logic signed [41:0] tf;
    } t_tt;

    typedef struct packed {
        t_ray               ray;
        logic               miss;
        logic               n_le_t1;
        logic               n_ge_t0;
        logic               f_ge_t0;
        logic               f_le_t1;
        logic signed [31:0] tn;
        logic signed [31:0] tf;
        logic signed [63:0] zpn;
        logic signed [63:0] zpf;
    } t_tc;

    typedef struct packed {
        logic               hit;
        logic               far;
        logic               kind;
        logic signed [31:0] t;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } t_hsel;

    typedef struct packed {
        logic               hit;
        logic               far;
        logic               kind;
        logic signed [31:0] t;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [63:0] tdx;
        logic signed [63:0] tdy;
    } t_np;

    typedef struct packed {
        logic               hit;
        logic               far;
        logic               kind;
        logic signed [31:0] t;
        logic               sx;
        logic               sy;
        logic [63:0]        mx;
        logic [63:0]        my;
    } t_nm;

    typedef struct packed {
        logic               hit;
        logic               far;
        logic               kind;
        logic signed [31:0] t;
        logic               sx;
        logic               sy;
        logic               ovx;
        logic               ovy;
        logic               len0;
        logic [63:0]        len;
    } t_nside;

    logic [30:0]    r_radius;
    logic [30:0]    r_height;
    logic [LAT-1:0] r_vld;

    t_ray   r_ray [0:5];
    t_prd   r_prd, n_prd;
    t_abc   r_abc [0:3];
    t_abc   n_abc;
    t_pp    r_pph, r_ppc;
    t_pm    r_pmh, r_pmc;
    logic [127:0] r_hh, r_ac;
    t_sqrt  r_sqa [0:SQRT_STEPS];
    t_sd1   r_sda [0:SQRT_STEPS];
    t_num   r_num, n_num;
    t_tdiv  r_tdn [0:TDIV_STEPS];
    t_tdiv  r_tdf [0:TDIV_STEPS];
    t_tside r_tds [0:TDIV_STEPS];
    t_tt    r_tt, n_tt;
    t_tc    r_tc, n_tc;
    t_hsel  r_sel, n_sel;
    t_np    r_np, n_np;
    t_nm    r_nm [0:3];
    t_nm    n_nm;
    t_pp    r_ppx, r_ppy;
    t_pm    r_pmx, r_pmy;
    logic [127:0] r_fx, r_fy;
    t_sqrt  r_sqb [0:SQRT_STEPS];
    t_nm    r_sdb [0:SQRT_STEPS];
    t_ndiv  r_ndx [0:NDIV_STEPS];
    t_ndiv  r_ndy [0:NDIV_STEPS];
    t_nside r_nds [0:NDIV_STEPS];

    logic               r_hit, n_hit;
    logic               r_nvalid, n_nvalid;
    logic signed [31:0] r_distance, n_distance;
    logic signed [15:0] r_nx, n_nx;
    logic signed [15:0] r_ny, n_ny;

    logic [63:0]        sxy;
    logic [64:0]        c_val, c_neg_val;
    logic signed [64:0] h_neg;
    logic [127:0]       disc;
    logic signed [65:0] hx, nn, nf, nn_neg_val, nf_neg_val;
    logic [TDIV_STEPS-1:0] tn_mag, tf_mag;
    logic signed [41:0] tmin_x, tmax_x;
    logic signed [64:0] oz_s, zn, zf, band;
    logic               inb_n, inb_f, near_ok, far_ok;
    logic signed [64:0] px, py, px_neg, py_neg;
    logic [NDIV_STEPS-1:0] qx, qy;
    logic signed [15:0] nx_m, ny_m;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS: r_radius <= i_cfg_wdata;
                CFG_HEIGHT: r_height <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    // Quadratic coefficients and discriminant.
    always_comb begin
        n_prd.dxx  = r_ray[0].dx * r_ray[0].dx;
        n_prd.dyy  = r_ray[0].dy * r_ray[0].dy;
        n_prd.oxx  = r_ray[0].ox * r_ray[0].ox;
        n_prd.oyy  = r_ray[0].oy * r_ray[0].oy;
        n_prd.oxdx = r_ray[0].ox * r_ray[0].dx;
        n_prd.oydy = r_ray[0].oy * r_ray[0].dy;
        n_prd.rr   = r_radius * r_radius;

        n_abc.a    = r_prd.dxx + r_prd.dyy;
        n_abc.h    = {r_prd.oxdx[63], r_prd.oxdx} + {r_prd.oydy[63], r_prd.oydy};
        h_neg      = -n_abc.h;
        n_abc.hm   = n_abc.h[64] ? h_neg[63:0] : n_abc.h[63:0];
        sxy        = r_prd.oxx + r_prd.oyy;
        c_val      = {1'b0, sxy} - {3'b000, r_prd.rr};
        c_neg_val  = -c_val;
        n_abc.cneg = c_val[64];
        n_abc.cm   = c_val[64] ? c_neg_val[63:0] : c_val[63:0];
        n_abc.miss = (n_abc.a == '0);

        disc = r_abc[3].cneg ? r_hh + r_ac : r_hh - r_ac;
    end

    always_ff @(posedge i_clk) begin
        r_ray[0].ox    <= i_origin_x;
        r_ray[0].oy    <= i_origin_y;
        r_ray[0].oz    <= i_origin_z;
        r_ray[0].dx    <= i_dir_x;
        r_ray[0].dy    <= i_dir_y;
        r_ray[0].dz    <= i_dir_z;
        r_ray[0].t_min <= i_t_min;
        r_ray[0].t_max <= i_t_max;
        r_ray[0].kind  <= i_ray_kind;
        r_prd          <= n_prd;
        r_abc[0]       <= n_abc;
        r_pph          <= mul_pp(r_abc[0].hm, r_abc[0].hm);
        r_ppc          <= mul_pp(r_abc[0].a, r_abc[0].cm);
        r_pmh          <= mul_mid(r_pph);
        r_pmc          <= mul_mid(r_ppc);
        r_hh           <= mul_fin(r_pmh);
        r_ac           <= mul_fin(r_pmc);
        r_sqa[0].rem   <= '0;
        r_sqa[0].root  <= '0;
        r_sqa[0].x     <= disc;
        r_sda[0].ray   <= r_ray[5];
        r_sda[0].miss  <= r_abc[3].miss || (!r_abc[3].cneg && (r_hh < r_ac));
        r_sda[0].a     <= r_abc[3].a;
        r_sda[0].h     <= r_abc[3].h;
    end

    for (genvar g = 1; g <= 5; g++) begin : g_ray_dly
        always_ff @(posedge i_clk) begin
            r_ray[g] <= r_ray[g-1];
        end
    end

    for (genvar g = 1; g <= 3; g++) begin : g_abc_dly
        always_ff @(posedge i_clk) begin
            r_abc[g] <= r_abc[g-1];
        end
    end

    for (genvar g = 1; g <= SQRT_STEPS; g++) begin : g_sqrt_a
        always_ff @(posedge i_clk) begin
            r_sqa[g] <= sqrt_step(r_sqa[g-1]);
            r_sda[g] <= r_sda[g-1];
        end
    end

    // Near and far root numerators, then the dividers by a.
    always_comb begin
        hx         = {r_sda[SQRT_STEPS].h[64], r_sda[SQRT_STEPS].h};
        nn         = -hx - {2'b00, r_sqa[SQRT_STEPS].root};
        nf         = {2'b00, r_sqa[SQRT_STEPS].root} - hx;
        nn_neg_val = -nn;
        nf_neg_val = -nf;
        n_num.ray    = r_sda[SQRT_STEPS].ray;
        n_num.miss   = r_sda[SQRT_STEPS].miss;
        n_num.a      = r_sda[SQRT_STEPS].a;
        n_num.nn_neg = nn[65];
        n_num.nn_mag = nn[65] ? nn_neg_val[64:0] : nn[64:0];
        n_num.nf_neg = nf[65];
        n_num.nf_mag = nf[65] ? nf_neg_val[64:0] : nf[64:0];
    end

    always_ff @(posedge i_clk) begin
        r_num            <= n_num;
        r_tdn[0].rem     <= {24'b0, r_num.nn_mag[64:25]};
        r_tdn[0].q       <= '0;
        r_tdn[0].n       <= {r_num.nn_mag[24:0], 16'b0};
        r_tdf[0].rem     <= {24'b0, r_num.nf_mag[64:25]};
        r_tdf[0].q       <= '0;
        r_tdf[0].n       <= {r_num.nf_mag[24:0], 16'b0};
        r_tds[0].ray     <= r_num.ray;
        r_tds[0].miss    <= r_num.miss;
        r_tds[0].a       <= r_num.a;
        r_tds[0].nn_neg  <= r_num.nn_neg;
        r_tds[0].nn_ovf  <= ({24'b0, r_num.nn_mag[64:25]} >= r_num.a);
        r_tds[0].nf_neg  <= r_num.nf_neg;
        r_tds[0].nf_ovf  <= ({24'b0, r_num.nf_mag[64:25]} >= r_num.a);
    end

    for (genvar g = 1; g <= TDIV_STEPS; g++) begin : g_tdiv
        logic [64:0] dn;
        logic [64:0] df;
        assign dn = div_step(r_tdn[g-1].rem, r_tdn[g-1].n[TDIV_STEPS-1], r_tds[g-1].a);
        assign df = div_step(r_tdf[g-1].rem, r_tdf[g-1].n[TDIV_STEPS-1], r_tds[g-1].a);
        always_ff @(posedge i_clk) begin
            r_tdn[g].rem <= dn[63:0];
            r_tdn[g].q   <= {r_tdn[g-1].q[TDIV_STEPS-2:0], dn[64]};
            r_tdn[g].n   <= {r_tdn[g-1].n[TDIV_STEPS-2:0], 1'b0};
            r_tdf[g].rem <= df[63:0];
            r_tdf[g].q   <= {r_tdf[g-1].q[TDIV_STEPS-2:0], df[64]};
            r_tdf[g].n   <= {r_tdf[g-1].n[TDIV_STEPS-2:0], 1'b0};
            r_tds[g]     <= r_tds[g-1];
        end
    end

    // Root clamp, interval and height band tests, root selection, hit point x and y magnitudes.
    always_comb begin
        tn_mag = (r_tds[TDIV_STEPS].nn_ovf || (r_tdn[TDIV_STEPS].q > T_LIMIT)) ?
                 T_LIMIT : r_tdn[TDIV_STEPS].q;
        tf_mag = (r_tds[TDIV_STEPS].nf_ovf || (r_tdf[TDIV_STEPS].q > T_LIMIT)) ?
                 T_LIMIT : r_tdf[TDIV_STEPS].q;
        n_tt.ray  = r_tds[TDIV_STEPS].ray;
        n_tt.miss = r_tds[TDIV_STEPS].miss;
        n_tt.tn   = r_tds[TDIV_STEPS].nn_neg ? -$signed({1'b0, tn_mag}) : $signed({1'b0, tn_mag});
        n_tt.tf   = r_tds[TDIV_STEPS].nf_neg ? -$signed({1'b0, tf_mag}) : $signed({1'b0, tf_mag});

        tmin_x     = {{10{r_tt.ray.t_min[31]}}, r_tt.ray.t_min};
        tmax_x     = {{10{r_tt.ray.t_max[31]}}, r_tt.ray.t_max};
        n_tc.ray     = r_tt.ray;
        n_tc.miss    = r_tt.miss;
        n_tc.n_le_t1 = $signed(r_tt.tn) <= tmax_x;
        n_tc.n_ge_t0 = $signed(r_tt.tn) >= tmin_x;
        n_tc.f_ge_t0 = $signed(r_tt.tf) >= tmin_x;
        n_tc.f_le_t1 = $signed(r_tt.tf) <= tmax_x;
        n_tc.tn      = r_tt.tn[31:0];
        n_tc.tf      = r_tt.tf[31:0];
        n_tc.zpn     = n_tc.tn * r_tt.ray.dz;
        n_tc.zpf     = n_tc.tf * r_tt.ray.dz;

        oz_s    = {{17{r_tc.ray.oz[31]}}, r_tc.ray.oz, 16'b0};
        zn      = oz_s + {r_tc.zpn[63], r_tc.zpn};
        zf      = oz_s + {r_tc.zpf[63], r_tc.zpf};
        band    = {19'b0, r_height, 15'b0};
        inb_n   = (zn <= band) && (zn >= -band);
        inb_f   = (zf <= band) && (zf >= -band);
        near_ok = r_tc.n_ge_t0 && inb_n;
        far_ok  = r_tc.f_ge_t0 && r_tc.f_le_t1 && inb_f;
        n_sel.hit  = !r_tc.miss && r_tc.n_le_t1 && (near_ok || far_ok);
        n_sel.far  = !near_ok;
        n_sel.kind = r_tc.ray.kind;
        n_sel.t    = near_ok ? r_tc.tn : r_tc.tf;
        n_sel.ox   = r_tc.ray.ox;
        n_sel.oy   = r_tc.ray.oy;
        n_sel.dx   = r_tc.ray.dx;
        n_sel.dy   = r_tc.ray.dy;

        n_np.hit  = r_sel.hit;
        n_np.far  = r_sel.far;
        n_np.kind = r_sel.kind;
        n_np.t    = r_sel.t;
        n_np.ox   = r_sel.ox;
        n_np.oy   = r_sel.oy;
        n_np.tdx  = r_sel.t * r_sel.dx;
        n_np.tdy  = r_sel.t * r_sel.dy;

        px     = {{17{r_np.ox[31]}}, r_np.ox, 16'b0} + {r_np.tdx[63], r_np.tdx};
        py     = {{17{r_np.oy[31]}}, r_np.oy, 16'b0} + {r_np.tdy[63], r_np.tdy};
        px_neg = -px;
        py_neg = -py;
        n_nm.hit  = r_np.hit;
        n_nm.far  = r_np.far;
        n_nm.kind = r_np.kind;
        n_nm.t    = r_np.t;
        n_nm.sx   = px[64];
        n_nm.sy   = py[64];
        n_nm.mx   = px[64] ? px_neg[63:0] : px[63:0];
        n_nm.my   = py[64] ? py_neg[63:0] : py[63:0];
    end

    always_ff @(posedge i_clk) begin
        r_tt          <= n_tt;
        r_tc          <= n_tc;
        r_sel         <= n_sel;
        r_np          <= n_np;
        r_nm[0]       <= n_nm;
        r_nm[1]       <= r_nm[0];
        r_nm[2]       <= r_nm[1];
        r_nm[3]       <= r_nm[2];
        r_ppx         <= mul_pp(r_nm[0].mx, r_nm[0].mx);
        r_ppy         <= mul_pp(r_nm[0].my, r_nm[0].my);
        r_pmx         <= mul_mid(r_ppx);
        r_pmy         <= mul_mid(r_ppy);
        r_fx          <= mul_fin(r_pmx);
        r_fy          <= mul_fin(r_pmy);
        r_sqb[0].rem  <= '0;
        r_sqb[0].root <= '0;
        r_sqb[0].x    <= r_fx + r_fy;
        r_sdb[0]      <= r_nm[3];
    end

    for (genvar g = 1; g <= SQRT_STEPS; g++) begin : g_sqrt_b
        always_ff @(posedge i_clk) begin
            r_sqb[g] <= sqrt_step(r_sqb[g-1]);
            r_sdb[g] <= r_sdb[g-1];
        end
    end

    // Normal components: |p| * 2^14 / len for each axis.
    always_ff @(posedge i_clk) begin
        r_ndx[0].rem  <= {1'b0, r_sdb[SQRT_STEPS].mx[63:1]};
        r_ndx[0].q    <= '0;
        r_ndx[0].n    <= {r_sdb[SQRT_STEPS].mx[0], 14'b0};
        r_ndy[0].rem  <= {1'b0, r_sdb[SQRT_STEPS].my[63:1]};
        r_ndy[0].q    <= '0;
        r_ndy[0].n    <= {r_sdb[SQRT_STEPS].my[0], 14'b0};
        r_nds[0].hit  <= r_sdb[SQRT_STEPS].hit;
        r_nds[0].far  <= r_sdb[SQRT_STEPS].far;
        r_nds[0].kind <= r_sdb[SQRT_STEPS].kind;
        r_nds[0].t    <= r_sdb[SQRT_STEPS].t;
        r_nds[0].sx   <= r_sdb[SQRT_STEPS].sx;
        r_nds[0].sy   <= r_sdb[SQRT_STEPS].sy;
        r_nds[0].ovx  <= ({1'b0, r_sdb[SQRT_STEPS].mx[63:1]} >= r_sqb[SQRT_STEPS].root);
        r_nds[0].ovy  <= ({1'b0, r_sdb[SQRT_STEPS].my[63:1]} >= r_sqb[SQRT_STEPS].root);
        r_nds[0].len0 <= (r_sqb[SQRT_STEPS].root == '0);
        r_nds[0].len  <= r_sqb[SQRT_STEPS].root;
    end

    for (genvar g = 1; g <= NDIV_STEPS; g++) begin : g_ndiv
        logic [64:0] dx_s;
        logic [64:0] dy_s;
        assign dx_s = div_step(r_ndx[g-1].rem, r_ndx[g-1].n[NDIV_STEPS-1], r_nds[g-1].len);
        assign dy_s = div_step(r_ndy[g-1].rem, r_ndy[g-1].n[NDIV_STEPS-1], r_nds[g-1].len);
        always_ff @(posedge i_clk) begin
            r_ndx[g].rem <= dx_s[63:0];
            r_ndx[g].q   <= {r_ndx[g-1].q[NDIV_STEPS-2:0], dx_s[64]};
            r_ndx[g].n   <= {r_ndx[g-1].n[NDIV_STEPS-2:0], 1'b0};
            r_ndy[g].rem <= dy_s[63:0];
            r_ndy[g].q   <= {r_ndy[g-1].q[NDIV_STEPS-2:0], dy_s[64]};
            r_ndy[g].n   <= {r_ndy[g-1].n[NDIV_STEPS-2:0], 1'b0};
            r_nds[g]     <= r_nds[g-1];
        end
    end

    always_comb begin
        qx = (r_nds[NDIV_STEPS].ovx || (r_ndx[NDIV_STEPS].q > NORM_ONE)) ?
             NORM_ONE : r_ndx[NDIV_STEPS].q;
        qy = (r_nds[NDIV_STEPS].ovy || (r_ndy[NDIV_STEPS].q > NORM_ONE)) ?
             NORM_ONE : r_ndy[NDIV_STEPS].q;
        nx_m = (r_nds[NDIV_STEPS].sx != r_nds[NDIV_STEPS].far) ?
               -$signed({1'b0, qx}) : $signed({1'b0, qx});
        ny_m = (r_nds[NDIV_STEPS].sy != r_nds[NDIV_STEPS].far) ?
               -$signed({1'b0, qy}) : $signed({1'b0, qy});
        n_hit      = r_vld[LAT-2] && r_nds[NDIV_STEPS].hit;
        n_nvalid   = n_hit && !(r_nds[NDIV_STEPS].far && r_nds[NDIV_STEPS].kind);
        n_distance = n_hit ? r_nds[NDIV_STEPS].t : '0;
        n_nx       = (n_nvalid && !r_nds[NDIV_STEPS].len0) ? nx_m : '0;
        n_ny       = (n_nvalid && !r_nds[NDIV_STEPS].len0) ? ny_m : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit    <= 1'b0;
            r_nvalid <= 1'b0;
        end else begin
            r_hit    <= n_hit;
            r_nvalid <= n_nvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_distance <= n_distance;
        r_nx       <= n_nx;
        r_ny       <= n_ny;
    end

    assign o_done         = r_vld[LAT-1];
    assign o_hit          = r_hit;
    assign o_distance     = r_distance;
    assign o_normal_valid = r_nvalid;
    assign o_normal_x     = r_nx;
    assign o_normal_y     = r_ny;
    assign o_normal_z     = 1'b0;

    `RCI_ASSERT_IMP(a_miss_clean, i_clk, i_rst_n, o_done && !o_hit, !o_normal_valid && o_distance == '0)
    `RCI_ASSERT_IMP(a_normal_bounded, i_clk, i_rst_n, o_normal_valid, o_hit && o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384 && o_normal_y <= 16'sd16384 && o_normal_y >= -16'sd16384)
    `RCI_ASSERT_NXT(a_hit_needs_item, i_clk, i_rst_n, !r_vld[LAT-2], !o_hit && !o_normal_valid)

endmodule
